// ===== hdl/pfb_pkg.sv =====
`timescale 1ns / 1ps

package pfb_pkg;

    // Screen and store geometry
    localparam int SCREEN_WIDTH   = 128;
    localparam int SCREEN_HEIGHT  = 64;
    localparam int PAGES          = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE_SIZE     = SCREEN_WIDTH * PAGES;
    localparam int STORE_AW       = $clog2(STORE_SIZE);
    localparam int X_AW           = $clog2(SCREEN_WIDTH);
    localparam int Y_AW           = $clog2(SCREEN_HEIGHT);

    // Signed pixel coordinate: origin plus bitmap offset plus bit offset
    localparam int COORD_W        = 11;
    localparam int MAX_BLIT_WIDTH = 128;

    // Command queue between front and back (depth is a power of two)
    localparam int Q_DEPTH        = 4;
    localparam int Q_AW           = $clog2(Q_DEPTH);

    // Configuration port
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 9;

    // A single pixel travels as the leftmost bit of a pixel mask
    localparam logic [7:0] PIXEL_MSB = 8'h80;

    typedef enum logic [1:0] {
        REQ_BLIT = 2'd0,
        REQ_PLOT = 2'd1,
        REQ_READ = 2'd2,
        REQ_FILL = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_SET    = 2'd1,
        MODE_INVERT = 2'd2,
        MODE_NONE   = 2'd3
    } pix_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_WIDTH    = 3'd2,
        CFG_HEIGHT   = 3'd3,
        CFG_COLOR    = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        CMD_PIXELS = 2'd0,
        CMD_READ   = 2'd1,
        CMD_FILL   = 2'd2
    } cmd_kind_t;

    typedef logic signed [COORD_W-1:0] coord_t;

    // One classified request; data is the pixel mask or the fill value
    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  data;
        coord_t      x;
        coord_t      y;
        pix_mode_t   mode;
        logic [9:0]  index;
    } cmd_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

    typedef enum logic [2:0] {
        BK_CLEAR     = 3'd0,
        BK_IDLE      = 3'd1,
        BK_PIX_SCAN  = 3'd2,
        BK_PIX_WRITE = 3'd3,
        BK_FILL      = 3'd4,
        BK_READ_WAIT = 3'd5
    } back_state_t;

    // Byte address of an on-screen pixel: column * PAGES + row / 8
    function automatic logic [STORE_AW-1:0] pixel_addr(
        input logic [X_AW-1:0] x,
        input logic [Y_AW-1:0] y
    );
        return STORE_AW'(int'(x) * PAGES + int'(y >> 3));
    endfunction

endpackage

// ===== hdl/pfb_queue.sv =====
`timescale 1ns / 1ps

module pfb_queue
    import pfb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    input  cmd_t push_cmd,
    output logic push_ready,
    output logic pop_valid,
    output cmd_t pop_cmd,
    input  logic pop
);

    cmd_t            q_mem [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != (Q_AW+1)'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = q_mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/pfb_front.sv =====
`timescale 1ns / 1ps

module pfb_front
    import pfb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            req_type,
    input  logic [7:0]            data_byte,
    input  logic signed [8:0]     plot_x,
    input  logic signed [8:0]     plot_y,
    input  logic [1:0]            plot_color,
    input  logic [9:0]            read_index,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  push_valid,
    output cmd_t                  push_cmd,
    input  logic                  push_ready,
    input  back_status_t          back_status
);

    logic signed [8:0] origin_x_reg;
    logic signed [8:0] origin_y_reg;
    logic [7:0]        width_reg;
    logic [6:0]        height_reg;
    pix_mode_t         color_reg;
    logic [6:0]        col_reg;
    logic [6:0]        col_next;
    logic [6:0]        row_reg;
    logic [6:0]        row_next;

    logic              accept;
    logic              cfg_hit;
    logic [7:0]        eff_w;
    logic [6:0]        eff_h;
    logic [7:0]        col_sum;
    logic [7:0]        row_inc;
    logic [7:0]        pad_mask;

    // Hold requests while the store is being cleared after reset
    assign in_ready   = push_ready && !back_status.clearing;
    assign push_valid = in_valid && !back_status.clearing;
    assign accept     = in_valid && in_ready;
    assign cfg_hit    = cfg_we && (cfg_index <= CFG_COLOR);

    // Clamp bitmap geometry
    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_w = 8'd1;
        end
        else if (width_reg > 8'(MAX_BLIT_WIDTH))
        begin
            eff_w = 8'(MAX_BLIT_WIDTH);
        end
        else
        begin
            eff_w = width_reg;
        end
        eff_h = (height_reg == '0) ? 7'd1 : height_reg;
    end

    // Drop the padding bits beyond the bitmap width
    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            pad_mask[7-b] = (({1'b0, col_reg} + 8'(b)) < eff_w);
        end
    end

    // Classify the request into a command for the back end
    always_comb
    begin
        push_cmd       = '0;
        push_cmd.index = read_index;
        unique case (req_type)
            REQ_BLIT:
            begin
                push_cmd.kind = CMD_PIXELS;
                push_cmd.data = data_byte & pad_mask;
                push_cmd.x    = coord_t'(origin_x_reg) + coord_t'(col_reg);
                push_cmd.y    = coord_t'(origin_y_reg) + coord_t'(row_reg);
                push_cmd.mode = color_reg;
            end
            REQ_PLOT:
            begin
                push_cmd.kind = CMD_PIXELS;
                push_cmd.data = PIXEL_MSB;
                push_cmd.x    = coord_t'(plot_x);
                push_cmd.y    = coord_t'(plot_y);
                push_cmd.mode = pix_mode_t'(plot_color);
            end
            REQ_READ:
            begin
                push_cmd.kind = CMD_READ;
            end
            REQ_FILL:
            begin
                push_cmd.kind = CMD_FILL;
                push_cmd.data = data_byte;
            end
            default:
            begin
                push_cmd.kind = CMD_READ;
            end
        endcase
    end

    // Step the bitmap cursor: columns by eight, then rows, then wrap
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        col_sum  = {1'b0, col_reg} + 8'd8;
        row_inc  = {1'b0, row_reg} + 8'd1;
        if (cfg_hit)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept && (req_type == REQ_BLIT))
        begin
            if (col_sum >= eff_w)
            begin
                col_next = '0;
                row_next = (row_inc >= {1'b0, eff_h}) ? '0 : row_inc[6:0];
            end
            else
            begin
                col_next = col_sum[6:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            width_reg    <= 8'd64;
            height_reg   <= 7'd64;
            color_reg    <= MODE_SET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ORIGIN_X: origin_x_reg <= $signed(cfg_data[8:0]);
                CFG_ORIGIN_Y: origin_y_reg <= $signed(cfg_data[8:0]);
                CFG_WIDTH:    width_reg    <= cfg_data[7:0];
                CFG_HEIGHT:   height_reg   <= cfg_data[6:0];
                CFG_COLOR:    color_reg    <= pix_mode_t'(cfg_data[1:0]);
                default:      ;
            endcase
        end
    end

endmodule

// ===== hdl/pfb_back.sv =====
`timescale 1ns / 1ps

module pfb_back
    import pfb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         pop_valid,
    input  cmd_t         pop_cmd,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [7:0]   read_data,
    output logic [9:0]   read_index_out,
    output back_status_t back_status
);

    logic [7:0]          store_mem [STORE_SIZE];

    back_state_t         state_reg;
    back_state_t         state_next;
    cmd_t                cmd_reg;
    logic [2:0]          bit_cnt_reg;
    logic [STORE_AW-1:0] fill_cnt_reg;
    logic [7:0]          fill_val_reg;
    logic [STORE_AW-1:0] pix_addr_reg;
    logic [7:0]          rd_data_reg;
    logic                out_valid_reg;
    logic [7:0]          read_data_reg;
    logic [9:0]          read_index_out_reg;

    coord_t              px;
    coord_t              py;
    logic                on_screen;
    logic                hit;
    logic                last_bit;
    logic                fill_done;
    logic [STORE_AW-1:0] pix_addr;
    logic [7:0]          row_bit;
    logic [7:0]          modified;

    logic                mem_we;
    logic [STORE_AW-1:0] mem_waddr;
    logic [7:0]          mem_wdata;
    logic                mem_re;
    logic [STORE_AW-1:0] mem_raddr;
    logic                load_out;

    assign out_valid      = out_valid_reg;
    assign read_data      = read_data_reg;
    assign read_index_out = read_index_out_reg;
    assign back_status.clearing = (state_reg == BK_CLEAR);

    // Take a command; a read waits until the output register is free
    assign pop = (state_reg == BK_IDLE) && pop_valid
               && ((pop_cmd.kind != CMD_READ) || !out_valid_reg || out_ready);

    // Current pixel of the mask
    assign px        = cmd_reg.x + coord_t'(bit_cnt_reg);
    assign py        = cmd_reg.y;
    assign on_screen = !px[COORD_W-1] && (px < coord_t'(SCREEN_WIDTH))
                    && !py[COORD_W-1] && (py < coord_t'(SCREEN_HEIGHT));
    assign hit       = cmd_reg.data[3'd7 - bit_cnt_reg] && on_screen
                    && (cmd_reg.mode != MODE_NONE);
    assign pix_addr  = pixel_addr(px[X_AW-1:0], py[Y_AW-1:0]);
    assign last_bit  = (bit_cnt_reg == 3'd7);
    assign fill_done = (fill_cnt_reg == STORE_AW'(STORE_SIZE - 1));
    assign row_bit   = 8'd1 << cmd_reg.y[2:0];

    // Apply the pixel mode to the fetched byte
    always_comb
    begin
        unique case (cmd_reg.mode)
            MODE_CLEAR:  modified = rd_data_reg & ~row_bit;
            MODE_SET:    modified = rd_data_reg | row_bit;
            MODE_INVERT: modified = rd_data_reg ^ row_bit;
            MODE_NONE:   modified = rd_data_reg;
            default:     modified = rd_data_reg;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_CLEAR, BK_FILL:
            begin
                if (fill_done)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (pop)
                begin
                    unique case (pop_cmd.kind)
                        CMD_PIXELS: state_next = BK_PIX_SCAN;
                        CMD_READ:   state_next = BK_READ_WAIT;
                        CMD_FILL:   state_next = BK_FILL;
                        default:    state_next = BK_IDLE;
                    endcase
                end
            end
            BK_PIX_SCAN:
            begin
                if (hit)
                begin
                    state_next = BK_PIX_WRITE;
                end
                else if (last_bit)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_PIX_WRITE:
            begin
                state_next = last_bit ? BK_IDLE : BK_PIX_SCAN;
            end
            BK_READ_WAIT:
            begin
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Memory controls per state
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = pix_addr_reg;
        mem_wdata = modified;
        mem_re    = 1'b0;
        mem_raddr = pix_addr;
        load_out  = 1'b0;
        unique case (state_reg)
            BK_CLEAR, BK_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = fill_cnt_reg;
                mem_wdata = fill_val_reg;
            end
            BK_IDLE:
            begin
                if (pop && (pop_cmd.kind == CMD_READ))
                begin
                    mem_re    = 1'b1;
                    mem_raddr = STORE_AW'(pop_cmd.index);
                end
            end
            BK_PIX_SCAN:
            begin
                mem_re = hit;
            end
            BK_PIX_WRITE:
            begin
                mem_we = 1'b1;
            end
            BK_READ_WAIT:
            begin
                load_out = 1'b1;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Frame store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= store_mem[mem_raddr];
        end
    end

    // Latch the command, the pixel address and the read result
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= pop_cmd;
        end
        if (state_reg == BK_PIX_SCAN)
        begin
            pix_addr_reg <= pix_addr;
        end
        if (load_out)
        begin
            read_data_reg      <= (int'(cmd_reg.index) < STORE_SIZE) ? rd_data_reg : 8'd0;
            read_index_out_reg <= cmd_reg.index;
        end
    end

    // Advance state, counters and the output flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            bit_cnt_reg   <= '0;
            fill_cnt_reg  <= '0;
            fill_val_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (pop)
            begin
                bit_cnt_reg <= '0;
            end
            else if (((state_reg == BK_PIX_SCAN) && !hit && !last_bit)
                  || ((state_reg == BK_PIX_WRITE) && !last_bit))
            begin
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
            end

            if (pop && (pop_cmd.kind == CMD_FILL))
            begin
                fill_cnt_reg <= '0;
                fill_val_reg <= pop_cmd.data;
            end
            else if ((state_reg == BK_CLEAR) || (state_reg == BK_FILL))
            begin
                fill_cnt_reg <= fill_done ? '0 : fill_cnt_reg + 1'b1;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== hdl/page_framebuffer_blitter.sv =====
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// ------    ---------------------  ---------------------------------------------
// request   in_valid / in_ready    req_type data_byte plot_x plot_y plot_color
//                                  read_index
// result    out_valid / out_ready  read_data read_index_out (read requests only)
// config    cfg_we                 cfg_index cfg_data
//
// In the back end a plot or bitmap byte scans its pixel mask bit by bit, with one
// read-modify-write per lit pixel; a read fetches a single byte; a fill writes
// STORE_SIZE bytes, one byte per cycle.
// After reset a clearing pass writes zero to all STORE_SIZE bytes; in_ready stays
// low meanwhile. A four-entry command queue keeps accepting requests, until it is
// full, while the back end is busy or a result waits on out_ready.

module page_framebuffer_blitter
    import pfb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            req_type,
    input  logic [7:0]            data_byte,
    input  logic signed [8:0]     plot_x,
    input  logic signed [8:0]     plot_y,
    input  logic [1:0]            plot_color,
    input  logic [9:0]            read_index,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            read_data,
    output logic [9:0]            read_index_out
);

    logic         push_valid;
    cmd_t         push_cmd;
    logic         push_ready;
    logic         pop_valid;
    cmd_t         pop_cmd;
    logic         pop;
    back_status_t back_status;

    // Classify requests and track the bitmap cursor
    pfb_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .data_byte   (data_byte),
        .plot_x      (plot_x),
        .plot_y      (plot_y),
        .plot_color  (plot_color),
        .read_index  (read_index),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push_valid  (push_valid),
        .push_cmd    (push_cmd),
        .push_ready  (push_ready),
        .back_status (back_status)
    );

    // Decouple front and back
    pfb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd),
        .pop        (pop)
    );

    // Carry out commands on the frame store
    pfb_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .pop_valid      (pop_valid),
        .pop_cmd        (pop_cmd),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_data      (read_data),
        .read_index_out (read_index_out),
        .back_status    (back_status)
    );

endmodule

// ===== hdl/pfb_checker.sv =====
`timescale 1ns / 1ps

module pfb_checker
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [7:0]            read_data,
    input logic [9:0]            read_index_out
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data)
                                    && $stable(read_index_out))
        else $error("result changed while stalled");

    // A result is withdrawn only once taken
    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(out_ready))
        else $error("result dropped without handshake");

    // Reads go through the store one at a time: no result right after a take
    a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid)
        else $error("result follows a taken result too early");

    // Requests are held off from the release of reset, as the clearing pass begins
    a_clear_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !in_ready ##1 !in_ready ##1 !in_ready)
        else $error("request accepted during the clearing pass");

endmodule

bind page_framebuffer_blitter pfb_checker u_pfb_checker (.*);
